@@ hw/rtl/rsc_pkg.sv @@
`default_nettype none

package rsc_pkg;

	// Command codes carried in the func field
	typedef enum logic [2:0] {
		FUNC_TICK        = 3'd0,
		FUNC_START       = 3'd1,
		FUNC_STOP        = 3'd2,
		FUNC_RESET_MODE  = 3'd3,
		FUNC_FORCE_INFRA = 3'd4,
		FUNC_FORCE_PEER  = 3'd5,
		FUNC_TIMED_PEER  = 3'd6
	} rsc_func_t;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_LONG_SLOT    = 3'd0;
	localparam logic [2:0] REG_SHORT_SLOT   = 3'd1;
	localparam logic [2:0] REG_REQ_INTERVAL = 3'd2;
	localparam logic [2:0] REG_REQ_WINDOW   = 3'd3;
	localparam logic [2:0] REG_DISC_INTERVAL = 3'd4;

	localparam int unsigned ADDR_BITS = 5;

	// Register values after reset, in microseconds
	localparam logic [31:0] LONG_SLOT_RST     = 32'd59000000;
	localparam logic [31:0] SHORT_SLOT_RST    = 32'd230000;
	localparam logic [31:0] REQ_INTERVAL_RST  = 32'd40000;
	localparam logic [31:0] REQ_WINDOW_RST    = 32'd180000;
	localparam logic [31:0] DISC_INTERVAL_RST = 32'd150000;

	// Milliseconds to microseconds
	localparam logic [9:0] MS_TO_US = 10'd1000;

	typedef struct packed {
		logic [31:0] long_slot_us;
		logic [31:0] short_slot_us;
		logic [31:0] request_interval_us;
		logic [31:0] request_window_us;
		logic [31:0] discover_interval_us;
	} rsc_cfg_t;

	typedef struct packed {
		logic mode;
		logic running;
		logic send_requests;
		logic discover;
		logic wifi_disconnect;
		logic wifi_reconnect;
		logic mqtt_disconnect;
		logic mqtt_reconnect;
		logic mark_connecting;
		logic ping_backend;
	} rsc_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/radio_slot_carousel_unit.sv @@
`default_nettype none

// Radio slot carousel: steps a radio between a long infrastructure slot and
// a short peer slot, one command or tick per beat, each carrying the current
// microsecond time. Every input beat gives exactly one result beat with the
// mode, the running flag and the link pulses. An item is held in an input
// register, evaluated against the scheduler state combinationally and written
// into the result register, so a new beat is taken every cycle while the
// result side does not stall. A stall on the result side holds the input register
// and then stalls the input. Slot
// lengths and pulse intervals sit in five 32-bit registers on the APB port
// at byte addresses 0 to 16; write them only while no beat is in flight.
module radio_slot_carousel_unit #(
	parameter int unsigned TIME_BITS = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rsc_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Input beats
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    func,
	input  wire logic [TIME_BITS-1:0]          time_now,
	input  wire logic                          force_tick,
	input  wire logic [22:0]                   force_ms,
	// Result beats
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               mode,
	output logic                               running,
	output logic                               send_requests,
	output logic                               discover,
	output logic                               wifi_disconnect,
	output logic                               wifi_reconnect,
	output logic                               mqtt_disconnect,
	output logic                               mqtt_reconnect,
	output logic                               mark_connecting,
	output logic                               ping_backend
);

	rsc_pkg::rsc_cfg_t    cfg;
	rsc_pkg::rsc_result_t res;
	rsc_pkg::rsc_result_t res_s2;

	logic                 v_s1;
	logic [2:0]           func_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 ftick_s1;
	logic [22:0]          fms_s1;
	logic                 out_valid_q;
	logic                 adv;
	logic                 take;

	rsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rsc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.func_s1  (func_s1),
		.time_s1  (time_s1),
		.ftick_s1 (ftick_s1),
		.fms_s1   (fms_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// Move the held item on whenever the result register is free or draining
	assign adv      = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1  <= func;
			time_s1  <= time_now;
			ftick_s1 <= force_tick;
			fms_s1   <= force_ms;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign mode            = res_s2.mode;
	assign running         = res_s2.running;
	assign send_requests   = res_s2.send_requests;
	assign discover        = res_s2.discover;
	assign wifi_disconnect = res_s2.wifi_disconnect;
	assign wifi_reconnect  = res_s2.wifi_reconnect;
	assign mqtt_disconnect = res_s2.mqtt_disconnect;
	assign mqtt_reconnect  = res_s2.mqtt_reconnect;
	assign mark_connecting = res_s2.mark_connecting;
	assign ping_backend    = res_s2.ping_backend;

	// A result never both drops and restores the infrastructure link
	a_link_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_s2.wifi_disconnect && res_s2.wifi_reconnect))
		else $error("link drop and restore in one result");

	// Reconnect handling only comes with the return to infrastructure mode
	a_connect_in_infra: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_s2.mark_connecting) |->
			(res_s2.ping_backend && !res_s2.mode && res_s2.mqtt_reconnect))
		else $error("connecting pulse outside infrastructure return");

	// A held item waits while the result side is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && out_stall) |=> (v_s1 && $stable(time_s1)))
		else $error("held item lost under stall");

endmodule

`default_nettype wire

@@ hw/rtl/rsc_cfg_regs.sv @@
`default_nettype none

module rsc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rsc_pkg::ADDR_BITS-1:0]   paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	output rsc_pkg::rsc_cfg_t                    cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.long_slot_us         <= rsc_pkg::LONG_SLOT_RST;
			cfg.short_slot_us        <= rsc_pkg::SHORT_SLOT_RST;
			cfg.request_interval_us  <= rsc_pkg::REQ_INTERVAL_RST;
			cfg.request_window_us    <= rsc_pkg::REQ_WINDOW_RST;
			cfg.discover_interval_us <= rsc_pkg::DISC_INTERVAL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				rsc_pkg::REG_LONG_SLOT:     cfg.long_slot_us         <= pwdata;
				rsc_pkg::REG_SHORT_SLOT:    cfg.short_slot_us        <= pwdata;
				rsc_pkg::REG_REQ_INTERVAL:  cfg.request_interval_us  <= pwdata;
				rsc_pkg::REG_REQ_WINDOW:    cfg.request_window_us    <= pwdata;
				rsc_pkg::REG_DISC_INTERVAL: cfg.discover_interval_us <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back; unmapped addresses read as zero
	always_comb begin
		case (reg_idx)
			rsc_pkg::REG_LONG_SLOT:     prdata = cfg.long_slot_us;
			rsc_pkg::REG_SHORT_SLOT:    prdata = cfg.short_slot_us;
			rsc_pkg::REG_REQ_INTERVAL:  prdata = cfg.request_interval_us;
			rsc_pkg::REG_REQ_WINDOW:    prdata = cfg.request_window_us;
			rsc_pkg::REG_DISC_INTERVAL: prdata = cfg.discover_interval_us;
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/rsc_core.sv @@
`default_nettype none

module rsc_core #(
	parameter int unsigned TIME_BITS = 48
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic [2:0]             func_s1,
	input  wire logic [TIME_BITS-1:0]   time_s1,
	input  wire logic                   ftick_s1,
	input  wire logic [22:0]            fms_s1,
	input  wire rsc_pkg::rsc_cfg_t      cfg,
	output rsc_pkg::rsc_result_t        res
);

	// Scheduler state
	logic                 mode_q;
	logic                 run_q;
	logic                 timed_q;
	logic [TIME_BITS-1:0] slot_q;
	logic [TIME_BITS-1:0] req_q;
	logic [TIME_BITS-1:0] disc_q;
	logic [31:0]          flen_q;

	logic                 mode_d;
	logic                 run_d;
	logic                 timed_d;
	logic [TIME_BITS-1:0] slot_d;
	logic [TIME_BITS-1:0] req_d;
	logic [TIME_BITS-1:0] disc_d;
	logic [31:0]          flen_d;

	// Ages of the stamps, modulo the time width
	logic [TIME_BITS-1:0] age_slot;
	logic [TIME_BITS-1:0] age_req;
	logic [TIME_BITS-1:0] age_disc;

	logic [32:0]          flen_prod;
	logic [31:0]          flen_sat;

	logic                 fire_req;
	logic                 fire_disc;
	logic                 to_peer;
	logic                 to_infra;
	logic                 expire;

	assign age_slot = time_s1 - slot_q;
	assign age_req  = time_s1 - req_q;
	assign age_disc = time_s1 - disc_q;

	// Convert the timed force length and saturate to 32 bits
	assign flen_prod = 33'(fms_s1) * 33'(rsc_pkg::MS_TO_US);
	assign flen_sat  = flen_prod[32] ? 32'hFFFF_FFFF : flen_prod[31:0];

	// Slot checks all see the stamps from before the tick; a switch into
	// the peer slot resets the slot age, and it never also ends the slot, as that check needs the old mode to be peer.
	assign fire_req  = mode_q && (age_req > TIME_BITS'(cfg.request_interval_us))
		&& (age_slot < TIME_BITS'(cfg.request_window_us));
	assign fire_disc = mode_q && (age_disc > TIME_BITS'(cfg.discover_interval_us));
	assign to_peer   = !mode_q && (age_slot > TIME_BITS'(cfg.long_slot_us));
	assign to_infra  = mode_q && (age_slot > TIME_BITS'(cfg.short_slot_us));
	assign expire    = age_req > TIME_BITS'(flen_q);

	// Work out next state and pulses for the held item
	always_comb begin
		mode_d  = mode_q;
		run_d   = run_q;
		timed_d = timed_q;
		slot_d  = slot_q;
		req_d   = req_q;
		disc_d  = disc_q;
		flen_d  = flen_q;
		res     = '0;

		case (rsc_pkg::rsc_func_t'(func_s1))
			rsc_pkg::FUNC_TICK: begin
				if (timed_q) begin
					if (expire) begin
						timed_d            = 1'b0;
						res.wifi_reconnect = 1'b1;
						res.mqtt_reconnect = 1'b1;
						slot_d             = time_s1;
					end
				end else if (run_q || ftick_s1) begin
					if (fire_req) begin
						req_d             = time_s1;
						res.send_requests = 1'b1;
					end
					if (fire_disc) begin
						disc_d       = time_s1;
						res.discover = 1'b1;
					end
					if (to_peer) begin
						mode_d              = 1'b1;
						res.mqtt_disconnect = 1'b1;
						res.wifi_disconnect = 1'b1;
						slot_d              = time_s1;
						req_d               = time_s1;
					end
					if (to_infra) begin
						slot_d              = time_s1;
						mode_d              = 1'b0;
						res.mark_connecting = 1'b1;
						res.wifi_reconnect  = 1'b1;
						res.mqtt_reconnect  = 1'b1;
						res.ping_backend    = 1'b1;
					end
				end
			end
			rsc_pkg::FUNC_START: begin
				if (!run_q) begin
					run_d  = 1'b1;
					slot_d = time_s1;
				end
			end
			rsc_pkg::FUNC_STOP: begin
				run_d = 1'b0;
			end
			rsc_pkg::FUNC_RESET_MODE: begin
				mode_d = 1'b0;
			end
			rsc_pkg::FUNC_FORCE_INFRA: begin
				run_d              = 1'b0;
				mode_d             = 1'b0;
				res.wifi_reconnect = 1'b1;
			end
			rsc_pkg::FUNC_FORCE_PEER: begin
				run_d               = 1'b0;
				mode_d              = 1'b1;
				res.wifi_disconnect = 1'b1;
			end
			rsc_pkg::FUNC_TIMED_PEER: begin
				timed_d             = 1'b1;
				flen_d              = flen_sat;
				req_d               = time_s1;
				run_d               = 1'b0;
				mode_d              = 1'b1;
				res.wifi_disconnect = 1'b1;
			end
			default: ;
		endcase

		res.mode    = mode_d;
		res.running = run_d;
	end

	// Commit the state as the item leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			run_q   <= 1'b0;
			timed_q <= 1'b0;
			slot_q  <= '0;
			req_q   <= '0;
			disc_q  <= '0;
			flen_q  <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			run_q   <= run_d;
			timed_q <= timed_d;
			slot_q  <= slot_d;
			req_q   <= req_d;
			disc_q  <= disc_d;
			flen_q  <= flen_d;
		end
	end

endmodule

`default_nettype wire
